@@ src/sbs_pkg.sv @@
// Package for the sorted bucket store: word types, sizes, status codes and
// the command and status structs between controller and datapath.
// No dependencies.
package sbs_pkg;

  localparam int MaxBuckets = 32;
  localparam int MaxHalf    = 8;
  localparam int BucketCap  = 2 * MaxHalf;
  localparam int ValueBits  = 32;
  localparam int BktW       = $clog2(MaxBuckets);
  localparam int SlotW      = $clog2(BucketCap);
  localparam int IdxW       = (BktW > SlotW + 1) ? BktW : SlotW + 1;
  localparam int CntW       = BktW + 1;
  localparam int HalfW      = 4;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]                  func;
    logic signed [ValueBits-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] leader;
    logic                        last;
    logic [1:0]                  status;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CREATE,
    OP_SEARCH,
    OP_LOAD,
    OP_INS_INIT,
    OP_INS_RD,
    OP_INS_SHIFT,
    OP_INS_PUT,
    OP_SPL_INIT,
    OP_SPL_RD,
    OP_SPL_WR,
    OP_REM_RD,
    OP_REM_NEXT,
    OP_REM_SH_RD,
    OP_REM_MV,
    OP_REM_FIN,
    OP_DUMP_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       emit;
    logic       emit_dump;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cnt_zero;
    logic       search_last;
    logic       full;
    logic       split;
    logic       idx_zero;
    logic       rd_le;
    logic       rd_eq;
    logic       idx_eq_n;
    logic       idx1_eq_n;
    logic       dump_last;
    logic       out_free;
  } dp_status_t;

endpackage

@@ src/sbs_ctrl.sv @@
// Controller state machine of the sorted bucket store.
// Depends on sbs_pkg; drives commands into sbs_dp and reads its status.
module sbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbs_pkg::dp_status_t sts_i,
  output sbs_pkg::dp_cmd_t    cmd_o
);
  import sbs_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SEARCH  = 4'd2;
  localparam logic [3:0] S_LOAD    = 4'd3;
  localparam logic [3:0] S_INS_CHK = 4'd4;
  localparam logic [3:0] S_INS_RD  = 4'd5;
  localparam logic [3:0] S_INS_CMP = 4'd6;
  localparam logic [3:0] S_INS_PUT = 4'd7;
  localparam logic [3:0] S_SPL_RD  = 4'd8;
  localparam logic [3:0] S_SPL_WR  = 4'd9;
  localparam logic [3:0] S_REM_RD  = 4'd10;
  localparam logic [3:0] S_REM_CMP = 4'd11;
  localparam logic [3:0] S_REM_SH  = 4'd12;
  localparam logic [3:0] S_REM_MV  = 4'd13;
  localparam logic [3:0] S_DUMP    = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] st_q, st_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    st_d          = st_q;
    cmd_o.op      = OP_NONE;
    cmd_o.emit    = 1'b0;
    cmd_o.emit_dump = 1'b0;
    cmd_o.status  = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d    = ST_DONE;
        state_d = S_EMIT;
        if (sts_i.func == FUNC_INSERT) begin
          if (sts_i.cnt_zero) begin
            cmd_o.op = OP_CREATE;
          end else begin
            state_d = S_SEARCH;
          end
        end else if (sts_i.func == FUNC_REMOVE) begin
          if (sts_i.cnt_zero) begin
            st_d = ST_NOTFOUND;
          end else begin
            state_d = S_SEARCH;
          end
        end else if (sts_i.func == FUNC_DUMP) begin
          if (sts_i.cnt_zero) begin
            st_d = ST_EMPTY;
          end else begin
            state_d = S_DUMP;
          end
        end
      end
      S_SEARCH: begin
        cmd_o.op = OP_SEARCH;
        if (sts_i.search_last) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = (sts_i.func == FUNC_INSERT) ? S_INS_CHK : S_REM_RD;
      end
      S_INS_CHK: begin
        if (sts_i.full) begin
          st_d    = ST_FULL;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_INS_INIT;
          state_d  = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts_i.idx_zero) begin
          state_d = S_INS_PUT;
        end else begin
          cmd_o.op = OP_INS_RD;
          state_d  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.rd_le) begin
          state_d = S_INS_PUT;
        end else begin
          cmd_o.op = OP_INS_SHIFT;
          state_d  = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        cmd_o.op = OP_INS_PUT;
        if (sts_i.split) begin
          state_d = S_SPL_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SPL_RD: begin
        if (sts_i.idx_eq_n) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_SPL_RD;
          state_d  = S_SPL_WR;
        end
      end
      S_SPL_WR: begin
        cmd_o.op = OP_SPL_WR;
        state_d  = S_SPL_RD;
      end
      S_REM_RD: begin
        if (sts_i.idx_eq_n) begin
          st_d    = ST_NOTFOUND;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_REM_RD;
          state_d  = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (sts_i.rd_eq) begin
          state_d = S_REM_SH;
        end else begin
          cmd_o.op = OP_REM_NEXT;
          state_d  = S_REM_RD;
        end
      end
      S_REM_SH: begin
        if (sts_i.idx1_eq_n) begin
          cmd_o.op = OP_REM_FIN;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = OP_REM_SH_RD;
          state_d  = S_REM_MV;
        end
      end
      S_REM_MV: begin
        cmd_o.op = OP_REM_MV;
        state_d  = S_REM_SH;
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.op        = OP_DUMP_STEP;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_dump = 1'b1;
          cmd_o.status    = ST_DONE;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // The split copy's set-up comes from the same step that places the value.
    if (state_q == S_INS_PUT && sts_i.split) begin
      cmd_o.op = OP_INS_PUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

@@ src/sbs_dp.sv @@
// Datapath of the sorted bucket store: value memory, bucket tables, scan
// registers, the half size register and the output word register.
// Depends on sbs_pkg; commanded by sbs_ctrl.
module sbs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbs_pkg::in_word_t   in_word_i,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sbs_pkg::out_word_t  out_word_o,
  input  sbs_pkg::dp_cmd_t    cmd_i,
  output sbs_pkg::dp_status_t sts_o
);
  import sbs_pkg::*;

  logic [ValueBits-1:0] mem_q [MaxBuckets*BucketCap];
  logic [ValueBits-1:0] rd_q;

  logic [ValueBits-1:0] lead_q  [MaxBuckets];
  logic [SlotW:0]       fill_q  [MaxBuckets];
  logic [BktW-1:0]      order_q [MaxBuckets];
  logic [CntW-1:0]      count_q;

  logic [HalfW-1:0]     half_cfg_q;
  logic [HalfW-1:0]     half_q;
  logic [1:0]           func_q;
  logic [ValueBits-1:0] val_q;
  logic [IdxW-1:0]      idx_q;
  logic [BktW-1:0]      t_q;
  logic [BktW-1:0]      p_q;
  logic [BktW-1:0]      q_q;
  logic [SlotW:0]       n_q;
  logic                 split_q;

  logic                 out_valid_q;
  out_word_t            out_q;

  logic [BktW-1:0]      cur_bkt;
  logic [SlotW:0]       n_load;
  logic                 rd_en;
  logic [BktW+SlotW-1:0] rd_addr;
  logic                 wr_en;
  logic [BktW+SlotW-1:0] wr_addr;
  logic [ValueBits-1:0] wr_data;
  logic [IdxW-1:0]      split_dst;
  logic [HalfW-1:0]     half_clamp;

  assign cur_bkt   = order_q[idx_q[BktW-1:0]];
  assign n_load    = (fill_q[order_q[t_q]] >= (SlotW+1)'(BucketCap)) ?
                     (SlotW+1)'(BucketCap - 1) : fill_q[order_q[t_q]];
  assign split_dst = idx_q - IdxW'(half_q);

  always_comb begin
    if (cfg_wdata_i == '0) begin
      half_clamp = HalfW'(1);
    end else if (cfg_wdata_i > HalfW'(MaxHalf)) begin
      half_clamp = HalfW'(MaxHalf);
    end else begin
      half_clamp = cfg_wdata_i;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {p_q, idx_q[SlotW-1:0]};
    wr_en   = 1'b0;
    wr_addr = {p_q, idx_q[SlotW-1:0]};
    wr_data = rd_q;
    case (cmd_i.op)
      OP_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = {p_q, idx_q[SlotW-1:0] - SlotW'(1)};
      end
      OP_SPL_RD, OP_REM_RD: begin
        rd_en = 1'b1;
      end
      OP_REM_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = {p_q, idx_q[SlotW-1:0] + SlotW'(1)};
      end
      OP_INS_SHIFT, OP_REM_MV: begin
        wr_en = 1'b1;
      end
      OP_INS_PUT: begin
        wr_en   = 1'b1;
        wr_data = val_q;
      end
      OP_CREATE: begin
        wr_en   = 1'b1;
        wr_addr = {order_q[0], SlotW'(0)};
        wr_data = val_q;
      end
      OP_SPL_WR: begin
        wr_en   = 1'b1;
        wr_addr = {q_q, split_dst[SlotW-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        func_q  <= in_word_i.func;
        val_q   <= in_word_i.value;
        half_q  <= half_cfg_q;
        idx_q   <= '0;
        t_q     <= '0;
      end
      OP_SEARCH: begin
        if ($signed(lead_q[cur_bkt]) <= $signed(val_q)) begin
          t_q <= idx_q[BktW-1:0];
        end
        idx_q <= idx_q + IdxW'(1);
      end
      OP_LOAD: begin
        p_q     <= order_q[t_q];
        n_q     <= n_load;
        split_q <= ({1'b0, n_load} + (SlotW+2)'(1)) >= (SlotW+2)'({half_q, 1'b0});
        idx_q   <= '0;
      end
      OP_INS_INIT: begin
        idx_q <= IdxW'(n_q);
      end
      OP_INS_SHIFT: begin
        idx_q <= idx_q - IdxW'(1);
      end
      OP_INS_PUT: begin
        n_q   <= n_q + (SlotW+1)'(1);
        idx_q <= IdxW'(half_q);
        q_q   <= order_q[count_q[BktW-1:0]];
      end
      OP_SPL_WR, OP_REM_NEXT, OP_REM_MV, OP_DUMP_STEP: begin
        idx_q <= idx_q + IdxW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_cfg_q <= HalfW'(4);
      count_q    <= '0;
      for (int i = 0; i < MaxBuckets; i++) begin
        fill_q[i]  <= '0;
        order_q[i] <= BktW'(i);
        lead_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        half_cfg_q <= half_clamp;
      end
      case (cmd_i.op)
        OP_CREATE: begin
          lead_q[order_q[0]] <= val_q;
          fill_q[order_q[0]] <= (SlotW+1)'(1);
          count_q            <= CntW'(1);
        end
        OP_INS_SHIFT: begin
          fill_q[p_q] <= fill_q[p_q];
        end
        OP_INS_PUT: begin
          if (idx_q == '0) begin
            lead_q[p_q] <= val_q;
          end
          if (split_q) begin
            fill_q[p_q] <= (SlotW+1)'(half_q);
            fill_q[order_q[count_q[BktW-1:0]]] <=
              n_q + (SlotW+1)'(1) - (SlotW+1)'(half_q);
            for (int i = 0; i < MaxBuckets; i++) begin
              if (CntW'(i) == CntW'(t_q) + CntW'(1)) begin
                order_q[i] <= order_q[count_q[BktW-1:0]];
              end else if (CntW'(i) > CntW'(t_q) + CntW'(1) && CntW'(i) <= count_q) begin
                order_q[i] <= order_q[i-1];
              end
            end
            count_q <= count_q + CntW'(1);
          end else begin
            fill_q[p_q] <= n_q + (SlotW+1)'(1);
          end
        end
        OP_SPL_WR: begin
          if (idx_q == IdxW'(half_q)) begin
            lead_q[q_q] <= rd_q;
          end
        end
        OP_REM_MV: begin
          if (idx_q == '0) begin
            lead_q[p_q] <= rd_q;
          end
        end
        OP_REM_FIN: begin
          fill_q[p_q] <= n_q - (SlotW+1)'(1);
          if (n_q == (SlotW+1)'(1)) begin
            for (int i = 0; i < MaxBuckets; i++) begin
              if (CntW'(i) == count_q - CntW'(1)) begin
                order_q[i] <= p_q;
              end else if (BktW'(i) >= t_q && CntW'(i) < count_q - CntW'(1)) begin
                order_q[i] <= order_q[(i + 1) % MaxBuckets];
              end
            end
            count_q <= count_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status <= cmd_i.status;
      if (cmd_i.emit_dump) begin
        out_q.leader <= lead_q[cur_bkt];
        out_q.last   <= sts_o.dump_last;
      end else begin
        out_q.leader <= '0;
        out_q.last   <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign sts_o.func        = func_q;
  assign sts_o.cnt_zero    = (count_q == '0);
  assign sts_o.search_last = (CntW'(idx_q) == count_q - CntW'(1));
  assign sts_o.full        = split_q && (count_q >= CntW'(MaxBuckets));
  assign sts_o.split       = split_q;
  assign sts_o.idx_zero    = (idx_q == '0);
  assign sts_o.rd_le       = ($signed(rd_q) <= $signed(val_q));
  assign sts_o.rd_eq       = (rd_q == val_q);
  assign sts_o.idx_eq_n    = (idx_q == IdxW'(n_q));
  assign sts_o.idx1_eq_n   = ((idx_q + IdxW'(1)) == IdxW'(n_q));
  assign sts_o.dump_last   = (CntW'(idx_q) == count_q - CntW'(1));
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

@@ src/sorted_bucket_store_split_core.sv @@
// Top level of the sorted bucket store: joins the controller and datapath.
// Depends on sbs_pkg, sbs_ctrl and sbs_dp.
//
// Keeps an ordered multiset of signed 32-bit values in up to 32 sorted
// buckets of up to 16 values each. One word is worked at a time; the input
// stalls from acceptance until its last result word is loaded into the
// output register, and a waiting result does not block the next accept.
// An operation runs a leader search over every bucket in use, then compares
// or moves values one at a time in the value memory through its single read
// port with registered data; a dump emits one word per bucket in use.
module sorted_bucket_store_split_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbs_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i
);
  import sbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  sbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ verif/sorted_bucket_store_split_checker.sv @@
// Checker for the sorted bucket store: watches the input and output channels,
// predicts the result words and compares them. Depends on sbs_pkg.
module sorted_bucket_store_split_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sbs_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sbs_pkg::out_word_t out_word_i,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbs_pkg::*;

  logic signed [ValueBits-1:0] vals[MaxBuckets][BucketCap];
  int fill[MaxBuckets];
  int order[MaxBuckets];
  int count;
  logic [3:0] half_reg;
  out_word_t expected_words[$];

  assign pending_o = expected_words.size();

  function automatic int find_bucket(logic signed [ValueBits-1:0] v);
    int t;
    t = 0;
    for (int i = 0; i < count; i++) begin
      if (vals[order[i]][0] <= v) begin
        t = i;
      end
    end
    return t;
  endfunction

  function automatic logic [1:0] store_insert(logic signed [ValueBits-1:0] v);
    int h, t, p, n, pos, q;
    bit split;
    h = (half_reg < 1) ? 1 : ((half_reg > MaxHalf) ? MaxHalf : int'(half_reg));
    if (count == 0) begin
      vals[order[0]][0] = v;
      fill[order[0]] = 1;
      count = 1;
      return ST_DONE;
    end
    t = find_bucket(v);
    p = order[t];
    n = fill[p];
    if (n >= BucketCap) n = BucketCap - 1;
    split = (n + 1 >= 2 * h);
    if (split && count >= MaxBuckets) return ST_FULL;
    pos = 0;
    while (pos < n && vals[p][pos] <= v) pos++;
    for (int i = n; i > pos; i--) vals[p][i] = vals[p][i-1];
    vals[p][pos] = v;
    n++;
    if (split) begin
      q = order[count];
      for (int i = count; i > t + 1; i--) order[i] = order[i-1];
      order[t+1] = q;
      for (int i = h; i < n; i++) vals[q][i-h] = vals[p][i];
      fill[q] = n - h;
      n = h;
      count++;
    end
    fill[p] = n;
    return ST_DONE;
  endfunction

  function automatic logic [1:0] store_remove(logic signed [ValueBits-1:0] v);
    int t, p, n, i;
    if (count == 0) return ST_NOTFOUND;
    t = find_bucket(v);
    p = order[t];
    n = fill[p];
    for (i = 0; i < n; i++) begin
      if (vals[p][i] == v) break;
    end
    if (i == n) return ST_NOTFOUND;
    for (int j = i; j + 1 < n; j++) vals[p][j] = vals[p][j+1];
    n--;
    fill[p] = n;
    if (n == 0) begin
      for (int j = t; j + 1 < count; j++) order[j] = order[j+1];
      order[count-1] = p;
      count--;
    end
    return ST_DONE;
  endfunction

  function automatic void predict_words(in_word_t w);
    out_word_t r;
    r = '0;
    r.last = 1'b1;
    case (w.func)
      FUNC_INSERT: r.status = store_insert(w.value);
      FUNC_REMOVE: r.status = store_remove(w.value);
      FUNC_DUMP: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < count; i++) begin
            r.leader = vals[order[i]][0];
            r.last = (i + 1 == count);
            r.status = ST_DONE;
            expected_words.insert(expected_words.size(), r);
          end
          return;
        end
      end
      default: r.status = ST_DONE;
    endcase
    expected_words.insert(expected_words.size(), r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      for (int i = 0; i < MaxBuckets; i++) begin
        fill[i] = 0;
        order[i] = i;
      end
      count = 0;
      half_reg = 4'd4;
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) half_reg = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_word_i.leader, 0);
        end else begin
          e = expected_words.pop_front();
          if (out_word_i.leader !== e.leader) report_mismatch("leader", out_word_i.leader, e.leader);
          if (out_word_i.last !== e.last) report_mismatch("last", out_word_i.last, e.last);
          if (out_word_i.status !== e.status) report_mismatch("status", out_word_i.status, e.status);
        end
      end
      if (in_valid_i && !in_stall_i) predict_words(in_word_i);
    end
  end
endmodule

@@ verif/sorted_bucket_store_split_core_test.sv @@
// Testbench top for the sorted bucket store: drives words and configuration,
// idles both sides and gives the verdict. Depends on sbs_pkg, the core and the checker.
module sorted_bucket_store_split_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sbs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  int fail_count;
  int pending;
  bit hold_long = 1'b0;
  logic signed [31:0] pool[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_bucket_store_split_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o, .cfg_we_i, .cfg_wdata_i
  );

  sorted_bucket_store_split_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_we_i, .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #20ms;
    $display("sorted_bucket_store_split_core verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    int mode;
    mode = int'(($time / 3000) % 3);
    if (hold_long) out_stall_i <= 1'b1;
    else if (mode == 0) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) < mode);
  end

  initial begin
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    hold_long = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_long = 1'b0;
  end

  task automatic send_word(logic [1:0] f, logic signed [31:0] v);
    in_valid_i <= 1'b1;
    in_word_i <= '{func: f, value: v};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_all();
    idle_cycles(1);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_half(logic [3:0] h);
    drain_all();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    if (pool.size() != 0 && $urandom_range(0, 2) == 0) return pool[$urandom_range(0, pool.size() - 1)];
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 60))) - 30;
      default: return $signed(32'($urandom_range(0, 400)));
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    logic [1:0] f;
    logic signed [31:0] v;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        idle_cycles($urandom_range(0, 6));
        burst = $urandom_range(1, 12);
      end
      burst--;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: f = FUNC_INSERT;
        5, 6, 7: f = FUNC_REMOVE;
        8: f = FUNC_DUMP;
        default: f = 2'd3;
      endcase
      v = pick_value();
      if (f == FUNC_INSERT) pool.insert(pool.size(), v);
      send_word(f, v);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(FUNC_DUMP, 0);
    send_word(FUNC_REMOVE, 5);
    send_word(FUNC_INSERT, 32'sh7fffffff);
    send_word(FUNC_INSERT, 32'sh80000000);
    send_word(FUNC_INSERT, 0);
    send_word(FUNC_INSERT, 0);
    send_word(FUNC_INSERT, -1);
    send_word(FUNC_INSERT, 32'sh55555555);
    send_word(FUNC_INSERT, 32'shaaaaaaaa);
    send_word(FUNC_INSERT, 3);
    send_word(FUNC_INSERT, 3);
    send_word(FUNC_DUMP, 0);
    send_word(FUNC_REMOVE, 0);
    send_word(FUNC_REMOVE, 77);
    send_word(2'd3, -1);
    send_word(FUNC_REMOVE, 32'sh80000000);
    send_word(FUNC_DUMP, 0);
    set_half(4'd1);
    for (int i = 0; i < 36; i++) send_word(FUNC_INSERT, 1000 + i);
    send_word(FUNC_DUMP, 0);
    for (int i = 0; i < 36; i++) send_word(FUNC_REMOVE, 1000 + i);
    set_half(4'd0);
    random_phase(18);
    set_half(4'd15);
    random_phase(18);
    set_half(4'd8);
    random_phase(18);
    set_half(4'd2);
    random_phase(18);
    drain_all();
    if (fail_count == 0) begin
      $display("sorted_bucket_store_split_core verification clean");
    end else begin
      $display("sorted_bucket_store_split_core verification failed");
    end
    $finish;
  end
endmodule

@@ sorted_bucket_store_split_core.f @@
src/sbs_pkg.sv
src/sbs_ctrl.sv
src/sbs_dp.sv
src/sorted_bucket_store_split_core.sv
verif/sorted_bucket_store_split_checker.sv
verif/sorted_bucket_store_split_core_test.sv
